[hw/rtl/udptl_receive_loss_recovery_defines.svh]
// Assertion macros used by the checker file of the receive block.
`ifndef UDPTL_RECEIVE_LOSS_RECOVERY_DEFINES_SVH
`define UDPTL_RECEIVE_LOSS_RECOVERY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDPTL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("udptl receive check failed");

// The consequent must hold in the cycle after the antecedent.
`define UDPTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("udptl receive check failed");

`endif

[hw/rtl/udptl_pkg.sv]
package udptl_pkg;

  localparam int unsigned MAX_SECONDARY = 7;
  localparam int unsigned SEQ_W = 16;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned BAD_W = 8;

  localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;
  localparam logic [BAD_W-1:0] BAD_LIMIT_RESET = 8'd10;
  localparam logic [BAD_W-1:0] BAD_SATURATE = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PRIMARY   = 2'd0,
    KIND_SECONDARY = 2'd1,
    KIND_FILLER    = 2'd2,
    KIND_ABORT     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_FILLER = 2'd0,
    CLS_ABORT  = 2'd1,
    CLS_PACKET = 2'd2
  } class_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

[hw/rtl/udptl_ctrl.sv]
module udptl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  udptl_pkg::status_t status_i,
  output udptl_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free && status_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/udptl_dpath.sv]
module udptl_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [udptl_pkg::BAD_W-1:0]       cfg_wdata_i,
  input  logic                              mode_i,
  input  logic                              decode_ok_i,
  input  logic [udptl_pkg::SEQ_W-1:0]       seq_in_i,
  input  logic [udptl_pkg::CNT_W-1:0]       secondary_count_i,
  input  udptl_pkg::cmd_t                   cmd_i,
  output udptl_pkg::status_t                status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        frame_kind_o,
  output logic [udptl_pkg::CNT_W-1:0]       secondary_index_o,
  output logic [udptl_pkg::SEQ_W-1:0]       seq_out_o,
  output logic [udptl_pkg::SEQ_W-1:0]       lost_count_o,
  output logic                              last_o
);

  localparam logic [udptl_pkg::CNT_W-1:0] MaxSec = udptl_pkg::CNT_W'(udptl_pkg::MAX_SECONDARY);

  logic [udptl_pkg::BAD_W-1:0] limit_q, bad_q, bad_d, bad_inc;
  logic [udptl_pkg::SEQ_W-1:0] exp_q, exp_d;

  logic                        in_mode_q, in_ok_q;
  logic [udptl_pkg::SEQ_W-1:0] in_seq_q;
  logic [udptl_pkg::CNT_W-1:0] in_cnt_q;

  udptl_pkg::class_e           cls_q, cls_d;
  logic [udptl_pkg::SEQ_W-1:0] cur_q, cur_d, lost_q, lost_d;
  logic [udptl_pkg::CNT_W-1:0] nred_q, nred_d;
  logic                        first_q;

  logic                        out_valid_q, last_q;
  logic [1:0]                  kind_q;
  logic [udptl_pkg::CNT_W-1:0] sidx_q;
  logic [udptl_pkg::SEQ_W-1:0] seq_q, lost_out_q;

  logic [udptl_pkg::SEQ_W-1:0] diff;
  logic [udptl_pkg::CNT_W-1:0] cnt_eff;
  logic                        neg;

  logic [1:0]                  r_kind;
  logic [udptl_pkg::CNT_W-1:0] r_sidx;
  logic [udptl_pkg::SEQ_W-1:0] r_seq, r_lost;
  logic                        r_last;

  // The sequence gap folds into -32768..32768; the exact half is positive
  // only when the carried sequence lies above the expected one.
  always_comb begin
    diff    = in_seq_q - exp_q;
    neg     = (diff > udptl_pkg::SEQ_HALF) ||
              ((diff == udptl_pkg::SEQ_HALF) && !in_seq_q[udptl_pkg::SEQ_W-1]);
    cnt_eff = (in_cnt_q > MaxSec) ? MaxSec : in_cnt_q;
    bad_inc = (bad_q == udptl_pkg::BAD_SATURATE) ? bad_q : bad_q + 1'b1;

    if (diff > {{(udptl_pkg::SEQ_W-udptl_pkg::CNT_W){1'b0}}, cnt_eff}) begin
      lost_d = diff - {{(udptl_pkg::SEQ_W-udptl_pkg::CNT_W){1'b0}}, cnt_eff};
      nred_d = cnt_eff;
      cur_d  = in_seq_q - {{(udptl_pkg::SEQ_W-udptl_pkg::CNT_W){1'b0}}, cnt_eff};
    end else begin
      lost_d = '0;
      nred_d = diff[udptl_pkg::CNT_W-1:0];
      cur_d  = exp_q;
    end

    bad_d = bad_q;
    if (in_mode_q) begin
      cls_d = udptl_pkg::CLS_FILLER;
    end else if (!in_ok_q) begin
      bad_d = bad_inc;
      cls_d = (bad_inc > limit_q) ? udptl_pkg::CLS_ABORT : udptl_pkg::CLS_FILLER;
    end else begin
      bad_d = '0;
      cls_d = neg ? udptl_pkg::CLS_FILLER : udptl_pkg::CLS_PACKET;
    end
  end

  always_comb begin
    r_kind = udptl_pkg::KIND_FILLER;
    r_sidx = '0;
    r_seq  = exp_q - 1'b1;
    r_lost = '0;
    r_last = 1'b1;
    exp_d  = exp_q;
    case (cls_q)
      udptl_pkg::CLS_ABORT: begin
        r_kind = udptl_pkg::KIND_ABORT;
        r_seq  = '0;
      end
      udptl_pkg::CLS_PACKET: begin
        r_seq  = cur_q;
        r_lost = first_q ? lost_q : '0;
        if (nred_q != '0) begin
          r_kind = udptl_pkg::KIND_SECONDARY;
          r_sidx = nred_q - 1'b1;
          r_last = 1'b0;
        end else begin
          r_kind = udptl_pkg::KIND_PRIMARY;
          exp_d  = cur_q + 1'b1;
        end
      end
      default: begin
        r_kind = udptl_pkg::KIND_FILLER;
      end
    endcase
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.emit_last = r_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= udptl_pkg::BAD_LIMIT_RESET;
      exp_q       <= '0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.calc) begin
        bad_q <= bad_d;
      end
      if (cmd_i.emit) begin
        exp_q       <= exp_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_mode_q <= mode_i;
      in_ok_q   <= decode_ok_i;
      in_seq_q  <= seq_in_i;
      in_cnt_q  <= secondary_count_i;
    end
    if (cmd_i.calc) begin
      cls_q   <= cls_d;
      cur_q   <= cur_d;
      lost_q  <= lost_d;
      nred_q  <= nred_d;
      first_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      kind_q     <= r_kind;
      sidx_q     <= r_sidx;
      seq_q      <= r_seq;
      lost_out_q <= r_lost;
      last_q     <= r_last;
      first_q    <= 1'b0;
      if (!r_last) begin
        nred_q <= nred_q - 1'b1;
        cur_q  <= cur_q + 1'b1;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_kind_o      = kind_q;
  assign secondary_index_o = sidx_q;
  assign seq_out_o         = seq_q;
  assign lost_count_o      = lost_out_q;
  assign last_o            = last_q;

endmodule

[hw/rtl/udptl_receive_loss_recovery.sv]
// An accepted input word is registered, evaluated in the calculate state and then
// emitted as n result words (1 to 8), one word per cycle while the output is free,
// in the controller's accept, evaluate and emit sequence; input waits for the last word.
// Reset: rst_ni is asynchronous and active low; it clears the expected sequence and
// the bad-packet run, loads the limit with 10 and leaves the output empty.
module udptl_receive_loss_recovery (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [udptl_pkg::BAD_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic                        decode_ok_i,
  input  logic [udptl_pkg::SEQ_W-1:0] seq_in_i,
  input  logic [udptl_pkg::CNT_W-1:0] secondary_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  frame_kind_o,
  output logic [udptl_pkg::CNT_W-1:0] secondary_index_o,
  output logic [udptl_pkg::SEQ_W-1:0] seq_out_o,
  output logic [udptl_pkg::SEQ_W-1:0] lost_count_o,
  output logic                        last_o
);

  udptl_pkg::cmd_t    cmd;
  udptl_pkg::status_t status;

  udptl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  udptl_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (mode_i),
    .decode_ok_i       (decode_ok_i),
    .seq_in_i          (seq_in_i),
    .secondary_count_i (secondary_count_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_kind_o      (frame_kind_o),
    .secondary_index_o (secondary_index_o),
    .seq_out_o         (seq_out_o),
    .lost_count_o      (lost_count_o),
    .last_o            (last_o)
  );

endmodule

[hw/rtl/udptl_checker.sv]
`include "udptl_receive_loss_recovery_defines.svh"

module udptl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  frame_kind_o,
  input logic [udptl_pkg::CNT_W-1:0] secondary_index_o,
  input logic [udptl_pkg::SEQ_W-1:0] seq_out_o,
  input logic                        last_o
);

  `UDPTL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(seq_out_o))
  `UDPTL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `UDPTL_ASSERT_NOW(a_index_only_secondary, out_valid_o && (frame_kind_o != udptl_pkg::KIND_SECONDARY), secondary_index_o == '0)
  `UDPTL_ASSERT_NOW(a_abort_single, out_valid_o && (frame_kind_o == udptl_pkg::KIND_ABORT), last_o && (seq_out_o == '0))

endmodule

bind udptl_receive_loss_recovery udptl_checker u_udptl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .frame_kind_o      (frame_kind_o),
  .secondary_index_o (secondary_index_o),
  .seq_out_o         (seq_out_o),
  .last_o            (last_o)
);
